/* hdl/adw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adw_pkg
// Shared widths, reset values, register codes and pipeline lengths for the
// AdaDelta weight update unit.
// ----------------------------------------------------------------------------
package adw_pkg;

    localparam int DATA_W   = 32;       // Q8.24 values
    localparam int CFG_W    = 25;       // decay and epsilon registers, Q1.24
    localparam int NCOL_W   = 7;
    localparam int IDX_W    = 6;        // row and column index fields
    localparam int IDX_N    = 1 << IDX_W;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 112;     // 108 bits of fields, padded to bytes
    localparam int M_TDATA_W = 64;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [CFG_W-1:0]  ONE_Q24         = 25'h100_0000;
    localparam logic [CFG_W-1:0]  DECAY_RATE_RST  = 25'd15938355;
    localparam logic [CFG_W-1:0]  EPSILON_RST     = 25'd17;
    localparam logic [NCOL_W-1:0] NUM_COLS_RST    = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_RATE = 2'd0,
        CFG_EPSILON    = 2'd1,
        CFG_NUM_COLS   = 2'd2
    } cfg_index_t;

    // square root: radicand (avg + eps) << 24 is 57 bits, padded to even width
    localparam int SQRT_RAD_W  = 58;
    localparam int SQRT_ROOT_W = SQRT_RAD_W / 2;
    localparam int SQRT_LANES  = 2;
    localparam int SQRT_TAG_W  = 4 * DATA_W;        // grad, weight, new gsq, old ssq

    // divider: |grad| * sa over sb
    localparam int DIV_DEN_W = SQRT_ROOT_W;
    localparam int DIV_NUM_W = DATA_W + SQRT_ROOT_W;
    localparam int DIV_Q_W   = DATA_W;
    localparam int DIV_TAG_W = 3 * DATA_W + 1;      // sign, weight, new gsq, old ssq

    // register stages ahead of the output register
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES  = 3;
    localparam int PIPE_LEN = FRONT_STAGES + SQRT_ROOT_W + 1 + DIV_Q_W + BACK_STAGES;

endpackage : adw_pkg
`default_nettype wire

/* hdl/adw_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module adw_ram #(
    parameter int WIDTH = adw_pkg::DATA_W,
    parameter int DEPTH = adw_pkg::MAX_ROWS_DEF * adw_pkg::MAX_COLS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : adw_ram
`default_nettype wire

/* hdl/adw_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adw_sqrt
// Pipelined integer square root, one root bit per stage, two lanes side by
// side, with a tag carried alongside.
// ----------------------------------------------------------------------------
module adw_sqrt #(
    parameter int RAD_W = adw_pkg::SQRT_RAD_W,
    parameter int TAG_W = adw_pkg::SQRT_TAG_W
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [RAD_W-1:0]   rad [adw_pkg::SQRT_LANES],
    input  wire logic [TAG_W-1:0]   tag_in,
    output logic      [RAD_W/2-1:0] root [adw_pkg::SQRT_LANES],
    output logic      [TAG_W-1:0]   tag_out
);
    import adw_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STAGES = ROOT_W;

    logic [RAD_W-1:0]  rad_reg  [STAGES][SQRT_LANES];
    logic [REM_W-1:0]  rem_reg  [STAGES][SQRT_LANES];
    logic [ROOT_W-1:0] root_reg [STAGES][SQRT_LANES];
    logic [TAG_W-1:0]  tag_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        for (genvar l = 0; l < SQRT_LANES; l++)
        begin : g_lane
            logic [RAD_W-1:0]  rad_cur;
            logic [REM_W-1:0]  rem_cur;
            logic [ROOT_W-1:0] root_cur;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              ge;

            if (s == 0)
            begin : g_first
                assign rad_cur  = rad[l];
                assign rem_cur  = '0;
                assign root_cur = '0;
            end
            else
            begin : g_rest
                assign rad_cur  = rad_reg[s-1][l];
                assign rem_cur  = rem_reg[s-1][l];
                assign root_cur = root_reg[s-1][l];
            end

            // bring down the next two radicand bits, try root*4+1
            assign rem_sh = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
            assign trial  = {root_cur, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[s][l]  <= rad_cur << 2;
                    rem_reg[s][l]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[s][l] <= {root_cur[ROOT_W-2:0], ge};
                end
            end
        end

        if (s == 0)
        begin : g_tag_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[s] <= tag_in;
                end
            end
        end
        else
        begin : g_tag_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[s] <= tag_reg[s-1];
                end
            end
        end
    end

    for (genvar l = 0; l < SQRT_LANES; l++)
    begin : g_out
        assign root[l] = root_reg[STAGES-1][l];
    end

    assign tag_out = tag_reg[STAGES-1];

endmodule : adw_sqrt
`default_nettype wire

/* hdl/adw_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adw_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit and a tag carried alongside.
// ----------------------------------------------------------------------------
module adw_div #(
    parameter int NUM_W = adw_pkg::DIV_NUM_W,
    parameter int DEN_W = adw_pkg::DIV_DEN_W,
    parameter int Q_W   = adw_pkg::DIV_Q_W,
    parameter int TAG_W = adw_pkg::DIV_TAG_W
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic      [Q_W-1:0]   quo,
    output logic                  ovf,
    output logic      [TAG_W-1:0] tag_out
);

    localparam int STAGES = Q_W;

    logic [NUM_W-1:0] rem_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [Q_W-1:0]   quo_reg [STAGES];
    logic             ovf_reg [STAGES];
    logic [TAG_W-1:0] tag_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] rem_cur;
        logic [DEN_W-1:0] den_cur;
        logic [Q_W-1:0]   quo_cur;
        logic             ovf_cur;
        logic [TAG_W-1:0] tag_cur;
        logic [NUM_W-1:0] dsh;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_cur = num;
            assign den_cur = den;
            assign quo_cur = '0;
            assign tag_cur = tag_in;
            // quotient needs more than Q_W bits
            assign ovf_cur = ({1'b0, num} >= ((NUM_W+1)'(den) << Q_W));
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[s-1];
            assign den_cur = den_reg[s-1];
            assign quo_cur = quo_reg[s-1];
            assign tag_cur = tag_reg[s-1];
            assign ovf_cur = ovf_reg[s-1];
        end

        assign dsh = NUM_W'(den_cur) << (Q_W - 1 - s);
        assign ge  = (rem_cur >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? (rem_cur - dsh) : rem_cur;
                den_reg[s] <= den_cur;
                quo_reg[s] <= {quo_cur[Q_W-2:0], ge};
                ovf_reg[s] <= ovf_cur;
                tag_reg[s] <= tag_cur;
            end
        end
    end

    assign quo     = quo_reg[STAGES-1];
    assign ovf     = ovf_reg[STAGES-1];
    assign tag_out = tag_reg[STAGES-1];

endmodule : adw_div
`default_nettype wire

/* hdl/adadelta_weight_update_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adadelta_weight_update_unit
// AdaDelta update of one weight element per transfer, Q8.24, with the squared
// gradient and squared step running averages held in two on-chip RAMs.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata: row_index, col_index, weight_in, row_gradient,
//           |           |        input_value
//  m_axis   | out       | tdata: weight_out, weight_step
//  cfg      | in        | cfg_index selects decay_rate, epsilon, num_cols
//
//  One element per cycle unless held off as described below; 71 pipeline stages
//  (multiplies, 29-stage square root, 32-stage divider; the first stage
//  captures on the transfer edge, the output register follows).
//  After reset both RAMs are zeroed, one entry a cycle, over all MAX_ROWS*MAX_COLS
//  entries (4096 by default) with s_axis_tready low.
//  An element whose address is still in the pipeline is held off until its
//  earlier update has been written back.
//  A stalled m_axis freezes the whole pipeline.
// ----------------------------------------------------------------------------
module adadelta_weight_update_unit #(
    parameter int MAX_ROWS = adw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = adw_pkg::MAX_COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // row_index[5:0], col_index[11:6], weight_in[43:12], row_gradient[75:44],
    // input_value[107:76], zero pad
    input  wire logic [adw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // weight_out[31:0], weight_step[63:32]
    output logic      [adw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [adw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [adw_pkg::CFG_W-1:0]      cfg_data
);
    import adw_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = CFG_W + DATA_W;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0]  decay_rate_reg;
    logic [CFG_W-1:0]  epsilon_reg;
    logic [NCOL_W-1:0] num_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg <= DECAY_RATE_RST;
            epsilon_reg    <= EPSILON_RST;
            num_cols_reg   <= NUM_COLS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DECAY_RATE: decay_rate_reg <= cfg_data;
                CFG_EPSILON:    epsilon_reg    <= cfg_data;
                CFG_NUM_COLS:   num_cols_reg   <= cfg_data[NCOL_W-1:0];
                default:        ;
            endcase
        end
    end

    logic [CFG_W-1:0] rho;
    logic [CFG_W-1:0] one_m_rho;
    logic [CFG_W-1:0] eps;

    assign rho       = (decay_rate_reg > ONE_Q24) ? ONE_Q24 : decay_rate_reg;
    assign one_m_rho = ONE_Q24 - rho;
    assign eps       = (epsilon_reg == '0) ? CFG_W'(1) : epsilon_reg;

    // ---------------- input and address ----------------
    logic [IDX_W-1:0]         in_row;
    logic [IDX_W-1:0]         in_col;
    logic signed [DATA_W-1:0] in_w;
    logic signed [DATA_W-1:0] in_g;
    logic signed [DATA_W-1:0] in_x;
    logic                     in_bias;
    logic [ADDR_W-1:0]        in_addr;

    assign in_row = s_axis_tdata[5:0];
    assign in_col = s_axis_tdata[11:6];
    assign in_w   = s_axis_tdata[43:12];
    assign in_g   = s_axis_tdata[75:44];
    assign in_x   = s_axis_tdata[107:76];

    assign in_bias = (num_cols_reg != '0) && ({1'b0, in_col} == (num_cols_reg - NCOL_W'(1)));

    // index wrap and row base folded into constant tables
    logic [ADDR_W-1:0] row_base [IDX_N];
    logic [ADDR_W-1:0] col_off  [IDX_N];

    for (genvar i = 0; i < IDX_N; i++)
    begin : g_addr_tbl
        assign row_base[i] = ADDR_W'((i % MAX_ROWS) * MAX_COLS);
        assign col_off[i]  = ADDR_W'(i % MAX_COLS);
    end

    assign in_addr = row_base[in_row] + col_off[in_col];

    // ---------------- pipeline control ----------------
    logic [PIPE_LEN-1:0] vld_line_reg;
    logic [ADDR_W-1:0]   addr_line_reg [PIPE_LEN];
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                clear_reg;
    logic [ADDR_W-1:0]   clear_cnt_reg;
    logic                adv;
    logic                hazard;
    logic                in_fire;
    logic                wb_fire;

    assign adv = !m_valid_reg || m_axis_tready;

    // same element still in flight: wait for its write-back
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < PIPE_LEN; k++)
        begin
            if (vld_line_reg[k] && (addr_line_reg[k] == in_addr))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign s_axis_tready = adv && !clear_reg && !hazard;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wb_fire       = adv && vld_line_reg[PIPE_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_line_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_line_reg <= {vld_line_reg[PIPE_LEN-2:0], in_fire};
            m_valid_reg  <= vld_line_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_line_reg[0] <= in_addr;
            for (int k = 1; k < PIPE_LEN; k++)
            begin
                addr_line_reg[k] <= addr_line_reg[k-1];
            end
        end
    end

    // RAM clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
            if (clear_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // ---------------- RAMs ----------------
    logic [DATA_W-1:0] gsq_rd;
    logic [DATA_W-1:0] ssq_rd;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] gsq_wdata;
    logic [DATA_W-1:0] ssq_wdata;
    logic [DATA_W-1:0] ssq_new;

    logic [DATA_W-1:0] l_gsq_reg;

    assign ram_we    = clear_reg || wb_fire;
    assign ram_waddr = clear_reg ? clear_cnt_reg : addr_line_reg[PIPE_LEN-1];
    assign gsq_wdata = clear_reg ? '0 : l_gsq_reg;
    assign ssq_wdata = clear_reg ? '0 : ssq_new;

    adw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_gsq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (gsq_wdata),
        .re    (adv),
        .raddr (in_addr),
        .rdata (gsq_rd)
    );

    adw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ssq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ssq_wdata),
        .re    (adv),
        .raddr (in_addr),
        .rdata (ssq_rd)
    );

    // ---------------- stage A: input capture, RAM read ----------------
    logic signed [DATA_W-1:0] a_w_reg, a_g_reg, a_x_reg;
    logic                     a_bias_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_w_reg    <= in_w;
            a_g_reg    <= in_g;
            a_x_reg    <= in_x;
            a_bias_reg <= in_bias;
        end
    end

    // ---------------- stage B: input * row gradient ----------------
    logic signed [2*DATA_W-1:0] b_prod_reg;
    logic signed [DATA_W-1:0]   b_g_reg;
    logic [DATA_W-1:0]          b_w_reg, b_gsq_reg, b_ssq_reg;
    logic                       b_bias_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_prod_reg <= a_x_reg * a_g_reg;
            b_g_reg    <= a_g_reg;
            b_w_reg    <= a_w_reg;
            b_bias_reg <= a_bias_reg;
            b_gsq_reg  <= gsq_rd;
            b_ssq_reg  <= ssq_rd;
        end
    end

    // ---------------- stage C: gradient ----------------
    logic [DATA_W-1:0] grad_next;
    logic [DATA_W-1:0] c_grad_reg, c_w_reg, c_gsq_reg, c_ssq_reg;

    always_comb
    begin
        if (b_bias_reg)
        begin
            grad_next = b_g_reg;
        end
        else if (b_prod_reg[63:55] == {9{b_prod_reg[55]}})
        begin
            grad_next = b_prod_reg[55:24];
        end
        else
        begin
            grad_next = b_prod_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_grad_reg <= grad_next;
            c_w_reg    <= b_w_reg;
            c_gsq_reg  <= b_gsq_reg;
            c_ssq_reg  <= b_ssq_reg;
        end
    end

    // ---------------- stage D: gradient squared ----------------
    logic [DATA_W-1:0]   c_grad_mag;
    logic [2*DATA_W-1:0] d_sqp_reg;
    logic [DATA_W-1:0]   d_grad_reg, d_w_reg, d_gsq_reg, d_ssq_reg;

    assign c_grad_mag = c_grad_reg[31] ? (~c_grad_reg + DATA_W'(1)) : c_grad_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_sqp_reg  <= c_grad_mag * c_grad_mag;
            d_grad_reg <= c_grad_reg;
            d_w_reg    <= c_w_reg;
            d_gsq_reg  <= c_gsq_reg;
            d_ssq_reg  <= c_ssq_reg;
        end
    end

    // ---------------- stage E: decay products ----------------
    logic [DATA_W-1:0] d_sqg;
    logic [PROD_W-1:0] e_p1_reg, e_p2_reg;
    logic [DATA_W-1:0] e_grad_reg, e_w_reg, e_ssq_reg;

    assign d_sqg = (d_sqp_reg[63:56] != '0) ? '1 : d_sqp_reg[55:24];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_p1_reg   <= rho * d_gsq_reg;
            e_p2_reg   <= one_m_rho * d_sqg;
            e_grad_reg <= d_grad_reg;
            e_w_reg    <= d_w_reg;
            e_ssq_reg  <= d_ssq_reg;
        end
    end

    // ---------------- stage F: new squared-gradient average ----------------
    logic [PROD_W:0]   e_sum;
    logic [DATA_W-1:0] f_gsq_reg, f_grad_reg, f_w_reg, f_ssq_reg;

    assign e_sum = {1'b0, e_p1_reg} + {1'b0, e_p2_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_gsq_reg  <= e_sum[55:24];
            f_grad_reg <= e_grad_reg;
            f_w_reg    <= e_w_reg;
            f_ssq_reg  <= e_ssq_reg;
        end
    end

    // ---------------- square roots ----------------
    logic [SQRT_RAD_W-1:0]  sq_rad  [SQRT_LANES];
    logic [SQRT_ROOT_W-1:0] sq_root [SQRT_LANES];
    logic [SQRT_TAG_W-1:0]  sq_tag_out;
    logic [DATA_W:0]        rad_a_sum, rad_b_sum;

    assign rad_a_sum = {1'b0, f_ssq_reg} + (DATA_W+1)'(eps);
    assign rad_b_sum = {1'b0, f_gsq_reg} + (DATA_W+1)'(eps);
    assign sq_rad[0] = {1'b0, rad_a_sum, 24'b0};
    assign sq_rad[1] = {1'b0, rad_b_sum, 24'b0};

    adw_sqrt #(
        .RAD_W (SQRT_RAD_W),
        .TAG_W (SQRT_TAG_W)
    ) u_sqrt (
        .clk     (clk),
        .en      (adv),
        .rad     (sq_rad),
        .tag_in  ({f_grad_reg, f_w_reg, f_gsq_reg, f_ssq_reg}),
        .root    (sq_root),
        .tag_out (sq_tag_out)
    );

    // ---------------- stage H: |grad| * sa ----------------
    logic [DATA_W-1:0]      s_grad, s_w, s_gsq, s_ssq, s_grad_mag;
    logic [SQRT_ROOT_W-1:0] s_sb;
    logic [DIV_NUM_W-1:0]   h_num_reg;
    logic [DIV_DEN_W-1:0]   h_den_reg;
    logic                   h_neg_reg;
    logic [DATA_W-1:0]      h_w_reg, h_gsq_reg, h_ssq_reg;

    assign {s_grad, s_w, s_gsq, s_ssq} = sq_tag_out;
    assign s_grad_mag = s_grad[31] ? (~s_grad + DATA_W'(1)) : s_grad;
    assign s_sb       = (sq_root[1] == '0) ? SQRT_ROOT_W'(1) : sq_root[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_num_reg <= s_grad_mag * sq_root[0];
            h_den_reg <= s_sb;
            h_neg_reg <= s_grad[31];
            h_w_reg   <= s_w;
            h_gsq_reg <= s_gsq;
            h_ssq_reg <= s_ssq;
        end
    end

    // ---------------- divider ----------------
    logic [DIV_Q_W-1:0]   dv_quo;
    logic                 dv_ovf;
    logic [DIV_TAG_W-1:0] dv_tag_out;

    adw_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .Q_W   (DIV_Q_W),
        .TAG_W (DIV_TAG_W)
    ) u_div (
        .clk     (clk),
        .en      (adv),
        .num     (h_num_reg),
        .den     (h_den_reg),
        .tag_in  ({h_neg_reg, h_w_reg, h_gsq_reg, h_ssq_reg}),
        .quo     (dv_quo),
        .ovf     (dv_ovf),
        .tag_out (dv_tag_out)
    );

    // ---------------- stage J: signed, saturated step ----------------
    logic              dv_neg;
    logic [DATA_W-1:0] dv_w, dv_gsq, dv_ssq;
    logic [DATA_W-1:0] step_next;
    logic [DATA_W-1:0] j_step_reg, j_w_reg, j_gsq_reg, j_ssq_reg;

    assign {dv_neg, dv_w, dv_gsq, dv_ssq} = dv_tag_out;

    always_comb
    begin
        if (!dv_neg)
        begin
            step_next = (dv_ovf || dv_quo[31]) ? 32'h7FFF_FFFF : dv_quo;
        end
        else if (dv_ovf || (dv_quo > 32'h8000_0000))
        begin
            step_next = 32'h8000_0000;
        end
        else
        begin
            step_next = ~dv_quo + DATA_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_step_reg <= step_next;
            j_w_reg    <= dv_w;
            j_gsq_reg  <= dv_gsq;
            j_ssq_reg  <= dv_ssq;
        end
    end

    // ---------------- stage K: step squared, new weight ----------------
    logic [DATA_W-1:0]   j_step_mag;
    logic [DATA_W:0]     j_diff;
    logic [DATA_W-1:0]   wout_next;
    logic [2*DATA_W-1:0] k_sqp_reg;
    logic [DATA_W-1:0]   k_step_reg, k_wout_reg, k_gsq_reg, k_ssq_reg;

    assign j_step_mag = j_step_reg[31] ? (~j_step_reg + DATA_W'(1)) : j_step_reg;
    assign j_diff     = {j_w_reg[31], j_w_reg} - {j_step_reg[31], j_step_reg};

    always_comb
    begin
        if (j_diff[32] != j_diff[31])
        begin
            wout_next = j_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            wout_next = j_diff[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_sqp_reg  <= j_step_mag * j_step_mag;
            k_step_reg <= j_step_reg;
            k_wout_reg <= wout_next;
            k_gsq_reg  <= j_gsq_reg;
            k_ssq_reg  <= j_ssq_reg;
        end
    end

    // ---------------- stage L: squared-step decay products ----------------
    logic [DATA_W-1:0] k_sqs;
    logic [PROD_W-1:0] l_p1_reg, l_p2_reg;
    logic [DATA_W-1:0] l_step_reg, l_wout_reg;
    logic [PROD_W:0]   l_sum;

    assign k_sqs = (k_sqp_reg[63:56] != '0) ? '1 : k_sqp_reg[55:24];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_p1_reg   <= rho * k_ssq_reg;
            l_p2_reg   <= one_m_rho * k_sqs;
            l_gsq_reg  <= k_gsq_reg;
            l_step_reg <= k_step_reg;
            l_wout_reg <= k_wout_reg;
        end
    end

    assign l_sum   = {1'b0, l_p1_reg} + {1'b0, l_p2_reg};
    assign ssq_new = l_sum[55:24];

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {l_step_reg, l_wout_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule : adadelta_weight_update_unit
`default_nettype wire
